// ===== sv/oacg_pkg.sv =====
package oacg_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_ROTATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CAP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DT        = 3'd5;

  // Field widths.
  localparam int unsigned RANGE_W = 14;
  localparam int unsigned CMD_W   = 16;
  localparam int unsigned MEAS_W  = 15;
  localparam int unsigned RATE_W  = 8;
  localparam int unsigned OUT_W   = 48;

  // Register reset values.
  localparam logic signed [CMD_W-1:0] CRUISE_SPEED_RST  = 16'sd1229;
  localparam logic signed [CMD_W-1:0] CRUISE_ROTATE_RST = 16'sd0;
  localparam logic [RANGE_W-1:0]      NEAR_LIMIT_RST    = 14'd1024;
  localparam logic [RANGE_W-1:0]      SLOW_LIMIT_RST    = 14'd2458;
  localparam logic [RANGE_W-1:0]      RANGE_CAP_RST     = 14'd4096;
  localparam logic [RATE_W-1:0]       INV_DT_RST        = 8'd5;

  // Divide by three: floor(s * 43691 / 2^17) is exact for every s below 2^17.
  localparam logic [15:0] RECIP3       = 16'd43691;
  localparam int unsigned RECIP3_SHIFT = 17;

  // Pose difference magnitudes saturate at this value before squaring.
  localparam logic [30:0] DELTA_SAT = 31'h7FFF_FFFF;

  // Largest value of the measured speed field.
  localparam logic [MEAS_W-1:0] MEAS_MAX = 15'h7FFF;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_AVG    = 6'b000010,
    ST_SQUARE = 6'b000100,
    ST_ROOT   = 6'b001000,
    ST_SCALE  = 6'b010000,
    ST_OUT    = 6'b100000
  } oacg_state_e;

endpackage

// ===== sv/obstacle_aware_cruise_governor_core.sv =====
// Obstacle-aware cruise governor. Each input transaction carries the left and right range
// readings and the pose x/y; each one yields exactly one output transaction with the speed
// command, the rotation command and the measured speed. The block works on one transaction at a
// time: it steps through averaging, squaring, square root, scaling and output, and s_axis_tready
// rises in the same cycle as m_axis_tvalid, so a new transaction can be taken as soon as the
// result is offered. The sequencer issues one shared 16x16 multiplier over 15 sequencer steps
// (range averages, the squared pose deltas in 16-bit halves, the speed scaling) and runs a
// bit-serial square root. A result waiting in the output register does not stop the next
// transaction from being accepted. Configuration writes are always taken and must only be
// issued while the block is idle.
module obstacle_aware_cruise_governor_core #(
  parameter int unsigned POSE_WIDTH = 32,
  localparam int unsigned InBits = 2 * oacg_pkg::RANGE_W + 2 * POSE_WIDTH,
  localparam int unsigned InW = ((InBits + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [oacg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [oacg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: range_left, range_right, pose_x, pose_y, zero padding.
  input  logic [InW-1:0]                   s_axis_tdata,
  // Output stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0 up: speed_out, rotate_out, measured_speed, zero padding.
  output logic [oacg_pkg::OUT_W-1:0]       m_axis_tdata
);

  localparam int unsigned DeltaW = POSE_WIDTH + 1;

  // Configuration registers.
  logic signed [oacg_pkg::CMD_W-1:0]   cruise_speed_q;
  logic signed [oacg_pkg::CMD_W-1:0]   cruise_rotate_q;
  logic [oacg_pkg::RANGE_W-1:0]        near_limit_q;
  logic [oacg_pkg::RANGE_W-1:0]        slow_limit_q;
  logic [oacg_pkg::RANGE_W-1:0]        range_cap_q;
  logic [oacg_pkg::RATE_W-1:0]         inv_dt_q;

  // State carried from tick to tick.
  logic [oacg_pkg::RANGE_W-1:0]        left_prev1_q, left_prev2_q;
  logic [oacg_pkg::RANGE_W-1:0]        right_prev1_q, right_prev2_q;
  logic [oacg_pkg::RANGE_W-1:0]        left_avg_prev_q;
  logic [POSE_WIDTH-1:0]               pose_x_prev_q, pose_y_prev_q;
  logic signed [oacg_pkg::CMD_W-1:0]   speed_reg_q, rotate_reg_q;

  // Sequencer.
  oacg_pkg::oacg_state_e               state_q, state_d;
  logic [4:0]                          step_q, step_d;
  logic                                sel_y_q;

  // Latched input item.
  logic [oacg_pkg::RANGE_W-1:0]        in_left_q, in_right_q;
  logic [POSE_WIDTH-1:0]               in_pose_x_q, in_pose_y_q;

  // Working registers.
  logic [oacg_pkg::RANGE_W-1:0]        left_avg_q, right_avg_q;
  logic [30:0]                         mag_q;
  logic [63:0]                         acc_q;
  logic [31:0]                         rem_q;
  logic [31:0]                         root_q;
  logic [39:0]                         meas_q;
  logic signed [23:0]                  diff_q;
  logic [31:0]                         prod_q;

  // Output register.
  logic                                out_valid_q, out_valid_d;
  logic signed [oacg_pkg::CMD_W-1:0]   out_speed_q, out_rotate_q;
  logic [oacg_pkg::MEAS_W-1:0]         out_meas_q;

  // Input unpacking and range capping.
  logic [oacg_pkg::RANGE_W-1:0]        range_left, range_right;
  logic [oacg_pkg::RANGE_W-1:0]        capped_left, capped_right;
  logic                                in_fire, out_fire;

  assign range_left   = s_axis_tdata[oacg_pkg::RANGE_W-1:0];
  assign range_right  = s_axis_tdata[oacg_pkg::RANGE_W +: oacg_pkg::RANGE_W];
  assign capped_left  = (range_left > range_cap_q) ? range_cap_q : range_left;
  assign capped_right = (range_right > range_cap_q) ? range_cap_q : range_right;

  assign s_axis_tready = (state_q == oacg_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = (state_q == oacg_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_speed_q  <= oacg_pkg::CRUISE_SPEED_RST;
      cruise_rotate_q <= oacg_pkg::CRUISE_ROTATE_RST;
      near_limit_q    <= oacg_pkg::NEAR_LIMIT_RST;
      slow_limit_q    <= oacg_pkg::SLOW_LIMIT_RST;
      range_cap_q     <= oacg_pkg::RANGE_CAP_RST;
      inv_dt_q        <= oacg_pkg::INV_DT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        oacg_pkg::CFG_CRUISE_SPEED:  cruise_speed_q  <= $signed(cfg_data_i);
        oacg_pkg::CFG_CRUISE_ROTATE: cruise_rotate_q <= $signed(cfg_data_i);
        oacg_pkg::CFG_NEAR_LIMIT:    near_limit_q    <= cfg_data_i[oacg_pkg::RANGE_W-1:0];
        oacg_pkg::CFG_SLOW_LIMIT:    slow_limit_q    <= cfg_data_i[oacg_pkg::RANGE_W-1:0];
        oacg_pkg::CFG_RANGE_CAP:     range_cap_q     <= cfg_data_i[oacg_pkg::RANGE_W-1:0];
        oacg_pkg::CFG_INV_DT:        inv_dt_q        <= cfg_data_i[oacg_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pose difference magnitude: one subtractor, x while averaging, y while squaring.
  logic                       pose_use_y;
  logic [POSE_WIDTH-1:0]      pose_cur, pose_prev;
  logic signed [DeltaW-1:0]   delta;
  logic [DeltaW-1:0]          delta_abs;
  logic [63:0]                delta_ext;
  logic [30:0]                mag_sat;

  assign pose_use_y = (state_q == oacg_pkg::ST_SQUARE);
  assign pose_cur   = pose_use_y ? in_pose_y_q : in_pose_x_q;
  assign pose_prev  = pose_use_y ? pose_y_prev_q : pose_x_prev_q;
  assign delta      = $signed({pose_cur[POSE_WIDTH-1], pose_cur})
                    - $signed({pose_prev[POSE_WIDTH-1], pose_prev});
  assign delta_abs  = delta[DeltaW-1] ? DeltaW'(-delta) : DeltaW'(delta);
  assign delta_ext  = 64'(delta_abs);
  assign mag_sat    = (delta_ext > 64'(oacg_pkg::DELTA_SAT)) ? oacg_pkg::DELTA_SAT
                                                             : delta_ext[30:0];

  // Range sums over the current and two previous capped readings.
  logic [15:0] left_sum, right_sum;
  assign left_sum  = 16'(in_left_q) + 16'(left_prev1_q) + 16'(left_prev2_q);
  assign right_sum = 16'(in_right_q) + 16'(right_prev1_q) + 16'(right_prev2_q);

  // Approach magnitude and direction from the fall of the left average.
  logic                         approach_neg;
  logic [oacg_pkg::RANGE_W-1:0] approach_mag;
  assign approach_neg = left_avg_q > left_avg_prev_q;
  assign approach_mag = approach_neg ? (left_avg_q - left_avg_prev_q)
                                     : (left_avg_prev_q - left_avg_q);

  // Shared multiplier operand selection.
  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      oacg_pkg::ST_AVG: begin
        mul_a = (step_q[1:0] == 2'd0) ? left_sum : right_sum;
        mul_b = oacg_pkg::RECIP3;
      end
      oacg_pkg::ST_SQUARE: begin
        case (step_q[1:0])
          2'd0: begin
            mul_a = mag_q[15:0];
            mul_b = mag_q[15:0];
          end
          2'd1: begin
            mul_a = {1'b0, mag_q[30:16]};
            mul_b = mag_q[15:0];
          end
          default: begin
            mul_a = {1'b0, mag_q[30:16]};
            mul_b = {1'b0, mag_q[30:16]};
          end
        endcase
      end
      oacg_pkg::ST_SCALE: begin
        mul_b = 16'(inv_dt_q);
        case (step_q[1:0])
          2'd0:    mul_a = root_q[15:0];
          2'd1:    mul_a = root_q[31:16];
          default: mul_a = 16'(approach_mag);
        endcase
      end
      default: ;
    endcase
  end

  assign prod = 32'(mul_a) * 32'(mul_b);

  // One restoring square root step: two radicand bits per cycle.
  logic [33:0] rem_try, root_trial;
  logic        root_ge;
  assign rem_try    = {rem_q, acc_q[63:62]};
  assign root_trial = {root_q, 2'b01};
  assign root_ge    = rem_try >= root_trial;

  // Decision and clamping of the speed command.
  logic                 left_slow, right_slow, slow_zone, stop_zone;
  logic signed [41:0]   slow_speed, cand_speed, cruise_ext, clamp_hi, clamp_lo;
  logic signed [oacg_pkg::CMD_W-1:0] final_speed, final_rotate;
  logic [oacg_pkg::MEAS_W-1:0]       final_meas;

  always_comb begin
    left_slow  = (left_avg_q < slow_limit_q) && (left_avg_q > near_limit_q);
    right_slow = (right_avg_q < slow_limit_q) && (right_avg_q > near_limit_q);
    slow_zone  = (speed_reg_q > 0) && (left_slow || right_slow);
    stop_zone  = (left_avg_q < near_limit_q) || (right_avg_q < near_limit_q);
    slow_speed = $signed({2'b00, meas_q}) - 42'(diff_q);
    cruise_ext = 42'(cruise_speed_q);
    if (slow_zone) begin
      cand_speed   = slow_speed;
      final_rotate = rotate_reg_q;
    end else if (stop_zone) begin
      cand_speed   = '0;
      final_rotate = '0;
    end else begin
      cand_speed   = cruise_ext;
      final_rotate = cruise_rotate_q;
    end
    clamp_hi = (cand_speed > cruise_ext) ? cruise_ext : cand_speed;
    clamp_lo = ((cruise_speed_q > 0) && (clamp_hi < 0)) ? '0 : clamp_hi;
    if (clamp_lo > 42'sd32767) begin
      final_speed = 16'sh7FFF;
    end else if (clamp_lo < -42'sd32768) begin
      final_speed = -16'sh8000;
    end else begin
      final_speed = clamp_lo[oacg_pkg::CMD_W-1:0];
    end
    final_meas = (meas_q > 40'(oacg_pkg::MEAS_MAX)) ? oacg_pkg::MEAS_MAX
                                                    : meas_q[oacg_pkg::MEAS_W-1:0];
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q + 5'd1;
    case (state_q)
      oacg_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_fire) begin
          state_d = oacg_pkg::ST_AVG;
        end
      end
      oacg_pkg::ST_AVG: begin
        if (step_q == 5'd2) begin
          state_d = oacg_pkg::ST_SQUARE;
          step_d  = '0;
        end
      end
      oacg_pkg::ST_SQUARE: begin
        if (step_q == 5'd3) begin
          step_d = '0;
          if (sel_y_q) begin
            state_d = oacg_pkg::ST_ROOT;
          end
        end
      end
      oacg_pkg::ST_ROOT: begin
        if (step_q == 5'd31) begin
          state_d = oacg_pkg::ST_SCALE;
          step_d  = '0;
        end
      end
      oacg_pkg::ST_SCALE: begin
        if (step_q == 5'd3) begin
          state_d = oacg_pkg::ST_OUT;
          step_d  = '0;
        end
      end
      oacg_pkg::ST_OUT: begin
        step_d = '0;
        if (out_fire) begin
          state_d = oacg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = oacg_pkg::ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  assign out_valid_d = out_fire || (out_valid_q && !m_axis_tready);

  // Control registers and tick-to-tick state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= oacg_pkg::ST_IDLE;
      step_q          <= '0;
      sel_y_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      left_prev1_q    <= '0;
      left_prev2_q    <= '0;
      right_prev1_q   <= '0;
      right_prev2_q   <= '0;
      left_avg_prev_q <= '0;
      pose_x_prev_q   <= '0;
      pose_y_prev_q   <= '0;
      speed_reg_q     <= '0;
      rotate_reg_q    <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        sel_y_q <= 1'b0;
      end else if ((state_q == oacg_pkg::ST_SQUARE) && (step_q == 5'd3)) begin
        sel_y_q <= 1'b1;
      end
      if (out_fire) begin
        left_prev2_q    <= left_prev1_q;
        left_prev1_q    <= in_left_q;
        right_prev2_q   <= right_prev1_q;
        right_prev1_q   <= in_right_q;
        left_avg_prev_q <= left_avg_q;
        pose_x_prev_q   <= in_pose_x_q;
        pose_y_prev_q   <= in_pose_y_q;
        speed_reg_q     <= final_speed;
        rotate_reg_q    <= final_rotate;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    if (in_fire) begin
      in_left_q   <= capped_left;
      in_right_q  <= capped_right;
      in_pose_x_q <= s_axis_tdata[2*oacg_pkg::RANGE_W +: POSE_WIDTH];
      in_pose_y_q <= s_axis_tdata[2*oacg_pkg::RANGE_W + POSE_WIDTH +: POSE_WIDTH];
      acc_q       <= '0;
    end
    case (state_q)
      oacg_pkg::ST_AVG: begin
        if (step_q == 5'd1) begin
          left_avg_q <= prod_q[oacg_pkg::RECIP3_SHIFT +: oacg_pkg::RANGE_W];
        end
        if (step_q == 5'd2) begin
          right_avg_q <= prod_q[oacg_pkg::RECIP3_SHIFT +: oacg_pkg::RANGE_W];
          mag_q       <= mag_sat;
        end
      end
      oacg_pkg::ST_SQUARE: begin
        // Square in halves: lo*lo, then 2*hi*lo at bit 16, then hi*hi at bit 32.
        case (step_q[1:0])
          2'd1: acc_q <= acc_q + 64'(prod_q);
          2'd2: acc_q <= acc_q + {15'd0, prod_q, 17'd0};
          2'd3: begin
            acc_q  <= acc_q + {prod_q, 32'd0};
            mag_q  <= mag_sat;
            rem_q  <= '0;
            root_q <= '0;
          end
          default: ;
        endcase
      end
      oacg_pkg::ST_ROOT: begin
        rem_q  <= root_ge ? 32'(rem_try - root_trial) : rem_try[31:0];
        root_q <= {root_q[30:0], root_ge};
        acc_q  <= {acc_q[61:0], 2'b00};
      end
      oacg_pkg::ST_SCALE: begin
        // The upper root half times the rate stays below 2^24.
        case (step_q[1:0])
          2'd1: meas_q <= 40'(prod_q);
          2'd2: meas_q <= meas_q + {prod_q[23:0], 16'd0};
          2'd3: diff_q <= approach_neg ? -$signed(24'(prod_q)) : $signed(24'(prod_q));
          default: ;
        endcase
      end
      default: ;
    endcase
    if (out_fire) begin
      out_speed_q  <= final_speed;
      out_rotate_q <= final_rotate;
      out_meas_q   <= final_meas;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_meas_q, out_rotate_q, out_speed_q};

  // An accepted transaction always starts with the averaging steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == oacg_pkg::ST_AVG))
    else $error("accepted transaction did not start the sequencer");

  // The squaring phase uses four multiplier steps per coordinate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oacg_pkg::ST_SQUARE) |-> (step_q <= 5'd3))
    else $error("square step counter out of range");

  // The square root runs its full 32 iterations.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == oacg_pkg::ST_ROOT) && (step_q != 5'd31)) |=> (state_q == oacg_pkg::ST_ROOT))
    else $error("square root left early");

  // A delivered speed never exceeds the cruise speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |=> ($signed(out_speed_q) <= $past(cruise_speed_q)))
    else $error("speed command above cruise speed");

  // With a positive cruise speed the command is never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (cruise_speed_q > 0)) |=> !out_speed_q[oacg_pkg::CMD_W-1])
    else $error("negative speed command with positive cruise speed");

endmodule

// ===== tb/oacg_checker.sv =====
`timescale 1ns / 100ps

module oacg_checker #(
  parameter int unsigned TickW = 96
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel, observed only.
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [oacg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [oacg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Sensor tick stream, observed only.
  input  logic                            tick_valid_i,
  input  logic                            tick_ready_i,
  // Fields from bit 0 up: range_left, range_right, pose_x, pose_y, zero padding.
  input  logic [TickW-1:0]                tick_data_i,
  // Command stream, observed only.
  input  logic                            cmd_valid_i,
  input  logic                            cmd_ready_i,
  // Fields from bit 0 up: speed_out, rotate_out, measured_speed, zero padding.
  input  logic [oacg_pkg::OUT_W-1:0]      cmd_data_i,
  output int                              mismatches_o,
  output int                              results_seen_o,
  output int                              outstanding_o
);

  // One command, laid out so that speed sits in the lowest bits as on the bus.
  typedef struct packed {
    logic [oacg_pkg::MEAS_W-1:0]       meas;
    logic signed [oacg_pkg::CMD_W-1:0] rotate;
    logic signed [oacg_pkg::CMD_W-1:0] speed;
  } command_t;

  command_t pending_cmds[$];

  // Register copies, tracked from the configuration channel.
  logic signed [oacg_pkg::CMD_W-1:0] cruise_spd;
  logic signed [oacg_pkg::CMD_W-1:0] cruise_rot;
  int unsigned             near_lim;
  int unsigned             slow_lim;
  int unsigned             cap;
  int unsigned             rate;

  // Governor history.
  int unsigned             left_hist1, left_hist2;
  int unsigned             right_hist1, right_hist2;
  int unsigned             left_avg_last;
  logic signed [31:0]      last_x, last_y;
  longint                  last_speed;
  logic signed [oacg_pkg::CMD_W-1:0] last_rotate;

  command_t got, want;

  // Magnitude of one pose coordinate change, saturated before squaring.
  function automatic longint unsigned pose_step(input logic signed [31:0] cur,
                                                input logic signed [31:0] prev);
    longint d;
    d = longint'(cur) - longint'(prev);
    if (d < 0) d = -d;
    if (d > oacg_pkg::DELTA_SAT) d = 64'(oacg_pkg::DELTA_SAT);
    return d;
  endfunction

  // Integer square root, rounded down, built one result bit at a time.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Works out the command for one tick and advances the governor history.
  function automatic command_t govern(input logic [TickW-1:0] tick);
    int unsigned             lc, rc, lavg, ravg;
    logic signed [31:0]      px, py;
    longint unsigned         dx, dy, meas;
    longint                  approach, spd;
    logic signed [oacg_pkg::CMD_W-1:0] rot;
    logic                    in_slow, in_stop;
    command_t                res;
    lc = 32'(tick[oacg_pkg::RANGE_W-1:0]);
    rc = 32'(tick[2*oacg_pkg::RANGE_W-1:oacg_pkg::RANGE_W]);
    px = tick[2*oacg_pkg::RANGE_W+31:2*oacg_pkg::RANGE_W];
    py = tick[2*oacg_pkg::RANGE_W+63:2*oacg_pkg::RANGE_W+32];
    if (lc > cap) lc = cap;
    if (rc > cap) rc = cap;
    lavg = (lc + left_hist1 + left_hist2) / 3;
    ravg = (rc + right_hist1 + right_hist2) / 3;

    dx = pose_step(px, last_x);
    dy = pose_step(py, last_y);
    meas = floor_root(dx * dx + dy * dy) * rate;
    approach = (longint'(left_avg_last) - longint'(lavg)) * longint'(rate);

    // An average sitting exactly on a limit is in neither zone.
    in_slow = (last_speed > 0) &&
              ((lavg < slow_lim && lavg > near_lim) || (ravg < slow_lim && ravg > near_lim));
    in_stop = (lavg < near_lim) || (ravg < near_lim);

    if (in_slow) begin
      spd = longint'(meas) - approach;
      rot = last_rotate;
    end else if (in_stop) begin
      spd = 0;
      rot = '0;
    end else begin
      spd = longint'(cruise_spd);
      rot = cruise_rot;
    end

    // Clamp against the cruise speed, then saturate to the command width.
    if (spd > longint'(cruise_spd)) spd = longint'(cruise_spd);
    if (cruise_spd > 0 && spd < 0) spd = 0;
    if (spd > 32767) spd = 32767;
    if (spd < -32768) spd = -32768;

    left_hist2    = left_hist1;
    left_hist1    = lc;
    right_hist2   = right_hist1;
    right_hist1   = rc;
    left_avg_last = lavg;
    last_x        = px;
    last_y        = py;
    last_speed    = spd;
    last_rotate   = rot;

    res.speed  = spd[oacg_pkg::CMD_W-1:0];
    res.rotate = rot;
    res.meas   = (meas > oacg_pkg::MEAS_MAX) ? oacg_pkg::MEAS_MAX
                                             : meas[oacg_pkg::MEAS_W-1:0];
    return res;
  endfunction

  task automatic flag_field(input string name, input longint exp_val, input longint act_val);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    mismatches_o++;
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_cmds.delete();
      cruise_spd     = oacg_pkg::CRUISE_SPEED_RST;
      cruise_rot     = oacg_pkg::CRUISE_ROTATE_RST;
      near_lim       = 32'(oacg_pkg::NEAR_LIMIT_RST);
      slow_lim       = 32'(oacg_pkg::SLOW_LIMIT_RST);
      cap            = 32'(oacg_pkg::RANGE_CAP_RST);
      rate           = 32'(oacg_pkg::INV_DT_RST);
      left_hist1     = 0;
      left_hist2     = 0;
      right_hist1    = 0;
      right_hist2    = 0;
      left_avg_last  = 0;
      last_x         = '0;
      last_y         = '0;
      last_speed     = 0;
      last_rotate    = '0;
      mismatches_o   = 0;
      results_seen_o = 0;
      outstanding_o  = 0;
    end else begin
      // Command transaction: compare against the oldest prediction.
      if (cmd_valid_i && cmd_ready_i) begin
        results_seen_o++;
        got = cmd_data_i[$bits(command_t)-1:0];
        if (pending_cmds.size() == 0) begin
          $display("%0t: command transaction with none expected, actual %h",
                   $time, cmd_data_i);
          mismatches_o++;
        end else begin
          want = pending_cmds.pop_front();
          if (got.speed !== want.speed)
            flag_field("speed_out", longint'(want.speed), longint'(got.speed));
          if (got.rotate !== want.rotate)
            flag_field("rotate_out", longint'(want.rotate), longint'(got.rotate));
          if (got.meas !== want.meas)
            flag_field("measured_speed", longint'(want.meas), longint'(got.meas));
        end
      end

      // Tick transaction: predict its command.
      if (tick_valid_i && tick_ready_i) begin
        pending_cmds.push_back(govern(tick_data_i));
      end

      // Register write transaction.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          oacg_pkg::CFG_CRUISE_SPEED:  cruise_spd = cfg_data_i;
          oacg_pkg::CFG_CRUISE_ROTATE: cruise_rot = cfg_data_i;
          oacg_pkg::CFG_NEAR_LIMIT:    near_lim   = 32'(cfg_data_i[oacg_pkg::RANGE_W-1:0]);
          oacg_pkg::CFG_SLOW_LIMIT:    slow_lim   = 32'(cfg_data_i[oacg_pkg::RANGE_W-1:0]);
          oacg_pkg::CFG_RANGE_CAP:     cap        = 32'(cfg_data_i[oacg_pkg::RANGE_W-1:0]);
          oacg_pkg::CFG_INV_DT:        rate       = 32'(cfg_data_i[oacg_pkg::RATE_W-1:0]);
          default: ;
        endcase
      end

      outstanding_o = pending_cmds.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned TickW      = 96;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned RangeMax   = 16383;
  localparam int unsigned RangeW     = oacg_pkg::RANGE_W;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [oacg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [oacg_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            tick_valid;
  logic                            tick_ready;
  logic [TickW-1:0]                tick_data;
  logic                            cmd_valid;
  logic                            cmd_ready;
  logic [oacg_pkg::OUT_W-1:0]      cmd_data;

  int mismatches, results_seen, outstanding;
  int sent;
  bit stall_enable;

  // Settings currently loaded, used to aim stimulus at the zone limits.
  logic [RangeW-1:0] set_near, set_slow, set_cap;

  // Smoothly moving obstacle distances and robot pose.
  int                 walk_left, walk_right;
  logic signed [31:0] walk_x, walk_y;

  obstacle_aware_cruise_governor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (tick_valid),
    .s_axis_tready (tick_ready),
    .s_axis_tdata  (tick_data),
    .m_axis_tvalid (cmd_valid),
    .m_axis_tready (cmd_ready),
    .m_axis_tdata  (cmd_data)
  );

  oacg_checker #(.TickW(TickW)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .tick_valid_i   (tick_valid),
    .tick_ready_i   (tick_ready),
    .tick_data_i    (tick_data),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_data_i     (cmd_data),
    .mismatches_o   (mismatches),
    .results_seen_o (results_seen),
    .outstanding_o  (outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Random back-pressure on the command stream.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ready <= 1'b0;
    end else begin
      cmd_ready <= !stall_enable || ($urandom_range(99) >= 11);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int clip_range(input int v);
    return (v < 0) ? 0 : ((v > int'(RangeMax)) ? int'(RangeMax) : v);
  endfunction

  // Present one tick, sometimes after an idle gap, and hold it until taken.
  task automatic send_tick(input logic [RangeW-1:0] rl, input logic [RangeW-1:0] rr,
                           input logic signed [31:0] px, input logic signed [31:0] py);
    if (stall_enable && $urandom_range(99) < 11) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(60, 1)) @(posedge clk_i);
    end
    tick_valid <= 1'b1;
    tick_data  <= {4'b0000, py, px, rr, rl};
    do @(posedge clk_i); while (!tick_ready);
    sent++;
  endtask

  task automatic write_reg(input logic [oacg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [oacg_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Load all six registers back to back; the block must be idle.
  task automatic apply_settings(input logic [15:0] spd, input logic [15:0] rot,
                                input logic [15:0] near, input logic [15:0] slow,
                                input logic [15:0] cap, input logic [15:0] rate);
    write_reg(oacg_pkg::CFG_CRUISE_SPEED, spd);
    write_reg(oacg_pkg::CFG_CRUISE_ROTATE, rot);
    write_reg(oacg_pkg::CFG_NEAR_LIMIT, near);
    write_reg(oacg_pkg::CFG_SLOW_LIMIT, slow);
    write_reg(oacg_pkg::CFG_RANGE_CAP, cap);
    write_reg(oacg_pkg::CFG_INV_DT, rate);
    cfg_valid <= 1'b0;
    set_near = near[RangeW-1:0];
    set_slow = slow[RangeW-1:0];
    set_cap  = cap[RangeW-1:0];
  endtask

  // A range that lands on or next to one of the configured limits, or at either end of the field.
  function automatic logic [RangeW-1:0] boundary_range();
    case ($urandom_range(6))
      0: return '0;
      1: return RangeW'(RangeMax);
      2: return set_near;
      3: return set_slow;
      4: return set_cap;
      5: return set_near + 1'b1;
      default: return set_slow - 1'b1;
    endcase
  endfunction

  // Mostly an obstacle drifting in and out with the robot moving in small steps;
  // otherwise pure noise, or a range held on a limit for three ticks.
  task automatic random_tick();
    int                pick;
    logic [RangeW-1:0] hold;
    pick = $urandom_range(99);
    if (pick < 75) begin
      if ($urandom_range(19) == 0 || walk_left == 0)
        walk_left = $urandom_range(RangeMax, set_near);
      if ($urandom_range(29) == 0 || walk_right == 0)
        walk_right = $urandom_range(RangeMax, set_near);
      walk_left  = clip_range(walk_left + int'($urandom_range(500)) - 350);
      walk_right = clip_range(walk_right + int'($urandom_range(500)) - 300);
      walk_x     = walk_x + int'($urandom_range(4000)) - 2000;
      walk_y     = walk_y + int'($urandom_range(4000)) - 2000;
      send_tick(walk_left[RangeW-1:0], walk_right[RangeW-1:0], walk_x, walk_y);
    end else if (pick < 90) begin
      send_tick(RangeW'($urandom), RangeW'($urandom), $urandom, $urandom);
    end else begin
      hold = boundary_range();
      for (int n = 0; n < 3; n++) begin
        walk_x = walk_x + int'($urandom_range(600)) - 300;
        if ($urandom_range(1)) send_tick(hold, RangeW'(RangeMax), walk_x, walk_y);
        else send_tick(RangeW'(RangeMax), hold, walk_x, walk_y);
      end
    end
  endtask

  initial begin
    int start_count;
    rst_ni       <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= oacg_pkg::CFG_CRUISE_SPEED;
    cfg_data     <= '0;
    tick_valid   <= 1'b0;
    tick_data    <= '0;
    stall_enable = 1'b1;
    sent         = 0;
    set_near     = oacg_pkg::NEAR_LIMIT_RST;
    set_slow     = oacg_pkg::SLOW_LIMIT_RST;
    set_cap      = oacg_pkg::RANGE_CAP_RST;
    walk_left    = RangeMax;
    walk_right   = RangeMax;
    walk_x       = '0;
    walk_y       = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks under the reset settings. The very first tick sees an
    // all-zero history and must stop.
    send_tick(14'd0, 14'd0, 32'sd0, 32'sd0);
    send_tick(14'd16383, 14'd16383, 32'sd0, 32'sd0);
    send_tick(14'd16383, 14'd16383, 32'sd4096, 32'sd0);
    send_tick(14'd16383, 14'd16383, 32'sd8192, 32'sd400);
    send_tick(14'd16383, 14'd16383, 32'sd9000, 32'sd800);
    // Pose swinging between the extremes: the larger differences saturate.
    send_tick(14'd16383, 14'd16383, 32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(14'd16383, 14'd16383, 32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(14'd16383, 14'd16383, 32'h8000_0400, 32'h7FFF_FC00);
    // Left range falling through the slow zone while moving, then held on
    // the slow limit and on the near limit.
    send_tick(14'd2458, 14'd16383, 32'h8000_0800, 32'h7FFF_F800);
    send_tick(14'd2458, 14'd16383, 32'h8000_0C00, 32'h7FFF_F400);
    send_tick(14'd2458, 14'd16383, 32'h8000_1000, 32'h7FFF_F000);
    send_tick(14'd1024, 14'd16383, 32'h8000_1400, 32'h7FFF_EC00);
    send_tick(14'd1024, 14'd16383, 32'h8000_1800, 32'h7FFF_E800);
    send_tick(14'd1024, 14'd16383, 32'h8000_1C00, 32'h7FFF_E400);
    send_tick(14'd1023, 14'd16383, 32'h8000_1C00, 32'h7FFF_E400);
    // Right side closes in while the left clears.
    send_tick(14'd4096, 14'd1500, 32'sd0, 32'sd0);
    send_tick(14'd4096, 14'd1500, 32'sd300, 32'sd0);
    send_tick(14'd4096, 14'd0, 32'sd600, 32'sd0);
    send_tick(14'd4096, 14'd0, 32'sd900, 32'sd0);
    send_tick(14'd16383, 14'd16383, 32'sd900, 32'sd0);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        tick_valid <= 1'b0;
        wait (results_seen == sent);
        case (phase)
          1: apply_settings(16'h7FFF, 16'h7FFF, 16'd0, 16'd16383, 16'd16383, 16'd255);
          // Inverted limits, zero cap and zero tick rate.
          2: apply_settings(16'h8000, 16'h8000, 16'd16383, 16'd0, 16'd0, 16'd0);
          3: apply_settings(16'h0000, 16'hFFFF, 16'd2000, 16'd8000, 16'd12000, 16'd1);
          4: apply_settings(16'hFE0C, 16'd300, 16'd1500, 16'd3000, 16'd5000, 16'd17);
          5: apply_settings(oacg_pkg::CRUISE_SPEED_RST, oacg_pkg::CRUISE_ROTATE_RST,
                            16'(oacg_pkg::NEAR_LIMIT_RST), 16'(oacg_pkg::SLOW_LIMIT_RST),
                            16'(oacg_pkg::RANGE_CAP_RST), 16'(oacg_pkg::INV_DT_RST));
          default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(4000)),
                                  16'($urandom_range(12000)), 16'($urandom),
                                  16'($urandom_range(255)));
        endcase
      end
      // One phase runs without any idling on either side.
      stall_enable = (phase != 4);
      start_count = sent;
      while (sent - start_count < PhaseItems) random_tick();
    end
    tick_valid <= 1'b0;

    // Drain and let the block settle before the verdict.
    wait (results_seen == sent);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/oacg_pkg.sv
sv/obstacle_aware_cruise_governor_core.sv
tb/oacg_checker.sv
tb/tb_top.sv
